// ===== src/hall_period_tachometer_unit_defines.svh =====
// assertion macros for the hall period tachometer unit
// no dependencies; the including module provides clk and rst
`ifndef HALL_PERIOD_TACHOMETER_UNIT_DEFINES_SVH
`define HALL_PERIOD_TACHOMETER_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF
// same-cycle implication
`define HPT_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("hpt check failed");
// next-cycle implication
`define HPT_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("hpt check failed");
`else
`define HPT_ASSERT_IMP(lbl, ante, cons)
`define HPT_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

// ===== src/hpt_pkg.sv =====
// shared constants and types for the hall period tachometer
// no dependencies
package hpt_pkg;

  localparam int COUNT_BITS_DEF = 16;
  localparam int NUM_BITS       = 32;
  localparam int SPEED_BITS     = 16;
  localparam int BCD_DIGITS     = 5;

  localparam logic [NUM_BITS-1:0]   NUMERATOR_RESET = 32'd14710800;
  localparam logic [SPEED_BITS-1:0] SPEED_MAX       = 16'hFFFF;

  // decimal digits of one speed value
  typedef struct packed {
    logic [6:0] thousands;
    logic [3:0] hundreds;
    logic [3:0] tens;
  } hpt_digits_t;

endpackage

// ===== src/hpt_div.sv =====
// bit-serial restoring divider: numerator / captured count, saturated to 16 bits
// depends on hpt_pkg
module hpt_div #(
  parameter int COUNT_BITS = hpt_pkg::COUNT_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic [hpt_pkg::NUM_BITS-1:0]    numerator,
  input  logic [COUNT_BITS-1:0]           divisor,
  output logic                            done,
  output logic [hpt_pkg::SPEED_BITS-1:0]  quotient
);

  localparam int NB        = hpt_pkg::NUM_BITS;
  localparam int SB        = hpt_pkg::SPEED_BITS;
  localparam int STEP_BITS = $clog2(NB);

  logic [NB-1:0]         work;
  logic [COUNT_BITS-1:0] rem;
  logic [COUNT_BITS-1:0] dvs;
  logic [STEP_BITS-1:0]  step;
  logic                  running;

  logic [COUNT_BITS:0]   rem_shift;
  logic [COUNT_BITS+1:0] diff;
  logic                  qbit;

  // one quotient bit per cycle
  always_comb begin
    rem_shift = {rem, work[NB-1]};
    diff      = {1'b0, rem_shift} - {2'b00, dvs};
    qbit      = ~diff[COUNT_BITS+1];
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      step    <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        step    <= '0;
      end else if (running) begin
        step <= step + STEP_BITS'(1);
        if (step == STEP_BITS'(NB - 1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  // datapath: numerator shifts out the top, quotient shifts in the bottom
  always_ff @(posedge clk) begin
    if (start) begin
      work <= numerator;
      rem  <= '0;
      dvs  <= divisor;
    end else if (running) begin
      work <= {work[NB-2:0], qbit};
      rem  <= qbit ? diff[COUNT_BITS-1:0] : rem_shift[COUNT_BITS-1:0];
    end
  end

  // saturate anything above 16 bits (a zero count lands here too)
  assign quotient = (|work[NB-1:SB]) ? hpt_pkg::SPEED_MAX : work[SB-1:0];

endmodule

// ===== src/hpt_bcd.sv =====
// bit-serial double-dabble conversion of the speed into decimal digits
// depends on hpt_pkg
module hpt_bcd (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic [hpt_pkg::SPEED_BITS-1:0]  value,
  output logic                            done,
  output hpt_pkg::hpt_digits_t            digits
);

  localparam int SB        = hpt_pkg::SPEED_BITS;
  localparam int DB        = 4 * hpt_pkg::BCD_DIGITS;
  localparam int STEP_BITS = $clog2(SB);

  logic [SB-1:0]        bin;
  logic [DB-1:0]        bcd;
  logic [DB-1:0]        adj;
  logic [STEP_BITS-1:0] step;
  logic                 running;
  logic [6:0]           ten_k;

  // add three to every digit of five or more before the shift
  always_comb begin
    for (int i = 0; i < hpt_pkg::BCD_DIGITS; i++) begin
      adj[4*i +: 4] = (bcd[4*i +: 4] >= 4'd5) ? bcd[4*i +: 4] + 4'd3 : bcd[4*i +: 4];
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      step    <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        step    <= '0;
      end else if (running) begin
        step <= step + STEP_BITS'(1);
        if (step == STEP_BITS'(SB - 1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  // shift one binary bit into the digit register per cycle
  always_ff @(posedge clk) begin
    if (start) begin
      bin <= value;
      bcd <= '0;
    end else if (running) begin
      bin <= {bin[SB-2:0], 1'b0};
      bcd <= {adj[DB-2:0], bin[SB-1]};
    end
  end

  // thousands field folds in the ten-thousands digit
  assign ten_k = {3'b000, bcd[19:16]};
  always_comb begin
    digits.thousands = {ten_k[3:0], 3'b000} + {ten_k[5:0], 1'b0} + {3'b000, bcd[15:12]};
    digits.hundreds  = bcd[11:8];
    digits.tens      = bcd[7:4];
  end

endmodule

// ===== src/hall_period_tachometer_unit.sv =====
// Hall period tachometer. Every input beat is one timer tick carrying the sampled
// hall level; a tick without a rising edge leaves the block ready for the next
// tick unless it wraps the counter. A rising edge hands the captured tick count
// to a bit-serial divider, one quotient bit at a time, and then to a bit-serial
// decimal converter, so an edge keeps in_stall high until its result reaches
// the staging register. A counter wrap gives an overflow result at once.
// in_stall also stays high while a finished result sits in the staging register
// behind a full output register.
// depends on hpt_pkg, hpt_div, hpt_bcd and hall_period_tachometer_unit_defines.svh
`include "hall_period_tachometer_unit_defines.svh"

module hall_period_tachometer_unit #(
  parameter int COUNT_BITS = hpt_pkg::COUNT_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // tick channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        hall_level,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] speed,
  output logic [6:0]  digit_thousands,
  output logic [3:0]  digit_hundreds,
  output logic [3:0]  digit_tens,
  output logic        overflow_error,
  // configuration write
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] speed_numerator
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_DIV  = 3'b010,
    ST_BCD  = 3'b100
  } hpt_state_t;

  hpt_state_t state;

  logic [31:0]           numerator;
  logic [COUNT_BITS-1:0] tick_count;
  logic                  prev_level;

  logic                  in_acc;
  logic                  rising;
  logic                  div_start;
  logic                  div_done;
  logic [15:0]           div_q;
  logic                  bcd_done;
  hpt_pkg::hpt_digits_t  bcd_digits;

  // staging register between the sequencer and the output register
  logic                  pend_valid;
  logic [15:0]           pend_speed;
  hpt_pkg::hpt_digits_t  pend_digits;
  logic                  pend_ovf;
  logic                  pend_move;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != ST_IDLE) || pend_valid;
  assign in_acc    = in_valid && !in_stall;
  assign rising    = hall_level && !prev_level;
  assign div_start = in_acc && rising;
  assign pend_move = pend_valid && (!out_valid || !out_stall);

  // numerator register
  always_ff @(posedge clk) begin
    if (rst) begin
      numerator <= hpt_pkg::NUMERATOR_RESET;
    end else if (cfg_valid && cfg_ready) begin
      numerator <= speed_numerator;
    end
  end

  // tick counter and edge detect
  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count <= '0;
      prev_level <= 1'b0;
    end else if (in_acc) begin
      prev_level <= hall_level;
      if (rising) begin
        tick_count <= '0;
      end else begin
        tick_count <= tick_count + {{(COUNT_BITS-1){1'b0}}, 1'b1};
      end
    end
  end

  // sequencer: idle, divide, convert
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (div_start) state <= ST_DIV;
        end
        ST_DIV: begin
          if (div_done) state <= ST_BCD;
        end
        ST_BCD: begin
          if (bcd_done) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  hpt_div #(
    .COUNT_BITS(COUNT_BITS)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .numerator (numerator),
    .divisor   (tick_count),
    .done      (div_done),
    .quotient  (div_q)
  );

  hpt_bcd u_bcd (
    .clk    (clk),
    .rst    (rst),
    .start  (div_done),
    .value  (div_q),
    .done   (bcd_done),
    .digits (bcd_digits)
  );

  // staging beat: overflow on wrap or a finished speed
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else begin
      priority if (bcd_done) begin
        pend_valid <= 1'b1;
      end else if (in_acc && !rising && (&tick_count)) begin
        pend_valid <= 1'b1;
      end else if (pend_move) begin
        pend_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    priority if (bcd_done) begin
      pend_speed  <= div_q;
      pend_digits <= bcd_digits;
      pend_ovf    <= 1'b0;
    end else if (in_acc && !rising && (&tick_count)) begin
      pend_speed  <= '0;
      pend_digits <= '0;
      pend_ovf    <= 1'b1;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pend_move) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pend_move) begin
      speed           <= pend_speed;
      digit_thousands <= pend_digits.thousands;
      digit_hundreds  <= pend_digits.hundreds;
      digit_tens      <= pend_digits.tens;
      overflow_error  <= pend_ovf;
    end
  end

  // checks
  `HPT_ASSERT_IMP(a_busy_no_pend, state != ST_IDLE, !pend_valid)
  `HPT_ASSERT_NXT(a_edge_starts, div_start, (state == ST_DIV) && (tick_count == '0))
  `HPT_ASSERT_NXT(a_div_to_bcd, (state == ST_DIV) && div_done, state == ST_BCD)
  `HPT_ASSERT_NXT(a_wrap_flags, in_acc && !rising && (&tick_count), pend_valid && pend_ovf)

endmodule

// ===== tb/sv/hall_period_tachometer_unit_test.sv =====
// self-checking bench for hall_period_tachometer_unit: tick beats in, speed readings out
// depends on hpt_pkg and the unit itself; the speed prediction is kept in a scoreboard class
module hall_period_tachometer_unit_test;

  localparam int CNT_W       = hpt_pkg::COUNT_BITS_DEF;
  localparam int SETTLE      = 64;
  localparam int HOLD_CYCLES = 400;
  localparam int CYCLE_LIMIT = 3000000;

  // one speed reading as it leaves the block
  typedef struct packed {
    logic [hpt_pkg::SPEED_BITS-1:0] speed;
    hpt_pkg::hpt_digits_t           digits;
    logic                           overflow;
  } reading_t;

  // predicts readings from accepted ticks and checks the ones that come out
  class speed_readings;
    reading_t                     pending_q[$];
    logic [hpt_pkg::NUM_BITS-1:0] numerator;
    logic [CNT_W-1:0]             ticks;
    logic                         last_level;
    int                           errors;
    int                           produced;

    function new();
      numerator  = hpt_pkg::NUMERATOR_RESET;
      ticks      = '0;
      last_level = 1'b0;
      errors     = 0;
      produced   = 0;
    endfunction

    function void note_tick(logic level);
      reading_t                       r;
      logic [hpt_pkg::NUM_BITS-1:0]   quot;
      logic [hpt_pkg::SPEED_BITS-1:0] s;
      int                             sv;
      r = '0;
      if (level && !last_level) begin
        // rising edge: capture the period and restart the count
        if (ticks == '0) begin
          s = hpt_pkg::SPEED_MAX;
        end else begin
          quot = numerator / 32'(ticks);
          s = (quot > 32'(hpt_pkg::SPEED_MAX)) ? hpt_pkg::SPEED_MAX : quot[15:0];
        end
        sv = int'(s);
        r.speed            = s;
        r.digits.thousands = 7'(sv / 1000);
        r.digits.hundreds  = 4'((sv % 1000) / 100);
        r.digits.tens      = 4'((sv % 100) / 10);
        ticks = '0;
        pending_q.push_back(r);
        produced++;
      end else begin
        // count on, a wrap to zero reports an overflow
        ticks = ticks + CNT_W'(1);
        if (ticks == '0) begin
          r.overflow = 1'b1;
          pending_q.push_back(r);
          produced++;
        end
      end
      last_level = level;
    endfunction

    function void compare_field(string label, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, label, want, got);
      end
    endfunction

    function void check_reading(reading_t got);
      reading_t want;
      if (pending_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected reading, expected none, got speed %0d overflow %0b",
                 $time, got.speed, got.overflow);
        return;
      end
      want = pending_q.pop_front();
      compare_field("speed", 32'(want.speed), 32'(got.speed));
      compare_field("digit_thousands", 32'(want.digits.thousands),
                    32'(got.digits.thousands));
      compare_field("digit_hundreds", 32'(want.digits.hundreds), 32'(got.digits.hundreds));
      compare_field("digit_tens", 32'(want.digits.tens), 32'(got.digits.tens));
      compare_field("overflow_error", 32'(want.overflow), 32'(got.overflow));
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        hall_level = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [15:0] speed;
  logic [6:0]  digit_thousands;
  logic [3:0]  digit_hundreds;
  logic [3:0]  digit_tens;
  logic        overflow_error;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [31:0] speed_numerator = hpt_pkg::NUMERATOR_RESET;

  speed_readings readings;
  bit            idle_on = 1'b1;
  bit            hold_req = 1'b0;
  int            hold_left = 0;
  int            cycle_count = 0;

  hall_period_tachometer_unit dut (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .hall_level      (hall_level),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .speed           (speed),
    .digit_thousands (digit_thousands),
    .digit_hundreds  (digit_hundreds),
    .digit_tens      (digit_tens),
    .overflow_error  (overflow_error),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .speed_numerator (speed_numerator)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  // result side: check each accepted beat, then choose the next stall
  always @(posedge clk) begin : result_sink
    reading_t seen;
    if (!rst && out_valid && !out_stall) begin
      seen.speed            = speed;
      seen.digits.thousands = digit_thousands;
      seen.digits.hundreds  = digit_hundreds;
      seen.digits.tens      = digit_tens;
      seen.overflow         = overflow_error;
      readings.check_reading(seen);
    end
    if (rst) begin
      out_stall <= 1'b0;
      hold_left <= 0;
    end else if (hold_req) begin
      hold_req = 1'b0;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= idle_on && ($urandom_range(99) < 11);
    end
  end

  // offer one tick beat and wait until it is taken
  task automatic send_tick(logic level);
    while (idle_on && $urandom_range(99) < 11) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    hall_level <= level;
    do @(posedge clk); while (in_stall);
    readings.note_tick(level);
  endtask

  task automatic send_run(logic level, int count);
    for (int i = 0; i < count; i++) send_tick(level);
  endtask

  // stop offering, wait for every reading, then let the divider go quiet
  task automatic settle();
    in_valid <= 1'b0;
    while (readings.pending_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_numerator(logic [31:0] value);
    cfg_valid       <= 1'b1;
    speed_numerator <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    readings.numerator = value;
  endtask

  // mostly clean periods of random length, some level noise
  task automatic random_ticks(int budget);
    int sent;
    int start;
    int pick;
    int lo;
    sent  = 0;
    start = readings.produced;
    while (sent < budget || readings.produced - start < 10) begin
      pick = $urandom_range(99);
      if (pick < 10) begin
        for (int i = 0; i < 16; i++) send_tick(1'($urandom_range(1)));
        sent += 16;
      end else begin
        pick = $urandom_range(99);
        if (pick < 80)      lo = $urandom_range(1, 20);
        else if (pick < 97) lo = $urandom_range(21, 200);
        else                lo = $urandom_range(201, 1500);
        pick = $urandom_range(1, 6);
        send_run(1'b0, lo);
        send_run(1'b1, pick);
        sent += lo + pick;
      end
    end
  endtask

  initial begin : watchdog
    wait (cycle_count >= CYCLE_LIMIT);
    $display("FAILURE");
    $finish;
  end

  initial begin : stimulus
    logic [31:0] num;
    readings = new();
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // high on the first tick is an edge with a zero count
    send_run(1'b1, 1);
    // short periods saturate, longer ones give real digits
    send_run(1'b0, 1);
    send_run(1'b1, 1);
    send_run(1'b0, 299);
    send_run(1'b1, 3);
    send_run(1'b0, 14710);
    send_run(1'b1, 1);
    send_run(1'b0, 1);
    // wrap without an edge, then an edge right after the wrap
    send_run(1'b0, 65535);
    send_run(1'b1, 1);
    // edge lands on the tick that would wrap
    send_run(1'b0, 65535);
    send_run(1'b1, 1);
    send_run(1'b0, 2);
    send_run(1'b1, 1);
    settle();

    // numerator settings, extremes included
    for (int p = 0; p < 7; p++) begin
      case (p)
        0:       num = 32'd1;
        1:       num = 32'd250000;
        2:       num = 32'd0;
        3:       num = 32'hFFFF_FFFF;
        4:       num = $urandom_range(2000, 2000000);
        5:       num = $urandom;
        default: num = hpt_pkg::NUMERATOR_RESET;
      endcase
      write_numerator(num);
      idle_on = (p != 3);
      if (p == 1) begin
        // result side held off while edges keep coming
        hold_req = 1'b1;
        for (int i = 0; i < 20; i++) begin
          send_tick(1'b0);
          send_tick(1'b1);
        end
        settle();
      end
      random_ticks(300);
      settle();
    end

    if (readings.errors == 0 && readings.pending_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+src
src/hpt_pkg.sv
src/hpt_div.sv
src/hpt_bcd.sv
src/hall_period_tachometer_unit.sv
tb/sv/hall_period_tachometer_unit_test.sv
